/* hw/rtl/i2cee_pkg.sv */
// Shared types and constants for the I2C EEPROM byte access master.
// Used by i2cee_core and i2c_eeprom_byte_access_master; depends on nothing.
package i2cee_pkg;

   localparam int unsigned AckLimitWidth = 8;
   localparam int unsigned SettleWidth   = 16;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [AckLimitWidth-1:0] AckWaitLimitReset     = 8'd255;
   localparam logic [SettleWidth-1:0]   WriteSettleTicksReset = 16'd5000;
   localparam logic [SettleWidth-1:0]   ReadSettleTicksReset  = 16'd100;

   localparam logic [7:0] DevSelWrite = 8'hA0;
   localparam logic [7:0] DevSelRead  = 8'hA1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ACK_WAIT_LIMIT     = 2'd0,
      CSR_WRITE_SETTLE_TICKS = 2'd1,
      CSR_READ_SETTLE_TICKS  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      STG_IDLE   = 4'd0,
      STG_START1 = 4'd1,
      STG_TXDEVW = 4'd2,
      STG_ACK1   = 4'd3,
      STG_TXADDR = 4'd4,
      STG_ACK2   = 4'd5,
      STG_TXDATA = 4'd6,
      STG_ACK3   = 4'd7,
      STG_START2 = 4'd8,
      STG_TXDEVR = 4'd9,
      STG_ACK4   = 4'd10,
      STG_RX     = 4'd11,
      STG_STOP   = 4'd12,
      STG_SETTLE = 4'd13
   } stage_type;

   typedef enum logic [1:0] {
      PH_0 = 2'd0,
      PH_1 = 2'd1,
      PH_2 = 2'd2,
      PH_3 = 2'd3
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic       write_op;
      logic [7:0] mem_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic [7:0] read_data;
      logic       done_res;
   } rsp_payload_type;

   typedef struct packed {
      logic [AckLimitWidth-1:0] ack_wait_limit;
      logic [SettleWidth-1:0]   write_settle_ticks;
      logic [SettleWidth-1:0]   read_settle_ticks;
   } cfg_type;

endpackage

/* hw/rtl/i2cee_core.sv */
// Phase sequencer of the I2C EEPROM master: sequence state and its next-state logic.
// Depends on i2cee_pkg for the stage codes and the payload and configuration structs.
module i2cee_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  i2cee_pkg::req_payload_type item,
   input  i2cee_pkg::cfg_type         cfg,
   output i2cee_pkg::rsp_payload_type result
);

   i2cee_pkg::stage_type stage_ff, stage_in;
   i2cee_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [i2cee_pkg::AckLimitWidth-1:0] ack_cnt_ff, ack_cnt_in;
   logic [i2cee_pkg::SettleWidth-1:0]   settle_ff, settle_in;
   logic        op_write_ff, op_write_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  rd_result_ff, rd_result_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        done;
   logic        enter;
   i2cee_pkg::stage_type enter_stage;
   logic [7:0]  rx_byte;
   logic [i2cee_pkg::SettleWidth-1:0] settle_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= i2cee_pkg::STG_IDLE;
         phase_ff     <= i2cee_pkg::PH_0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         ack_cnt_ff   <= '0;
         settle_ff    <= '0;
         op_write_ff  <= 1'b0;
         addr_ff      <= '0;
         data_ff      <= '0;
         rd_result_ff <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (step) begin
         stage_ff     <= stage_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         ack_cnt_ff   <= ack_cnt_in;
         settle_ff    <= settle_in;
         op_write_ff  <= op_write_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         rd_result_ff <= rd_result_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

   assign rx_byte      = {shift_ff[6:0], item.sda_in};
   assign settle_limit = op_write_ff ? cfg.write_settle_ticks : cfg.read_settle_ticks;

   always_comb begin
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      ack_cnt_in   = ack_cnt_ff;
      settle_in    = settle_ff;
      op_write_in  = op_write_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      rd_result_in = rd_result_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      done         = 1'b0;
      enter        = 1'b0;
      enter_stage  = i2cee_pkg::STG_IDLE;

      if (item.mode) begin
         // A command is taken only while idle; otherwise the item changes nothing.
         if (stage_ff == i2cee_pkg::STG_IDLE) begin
            op_write_in = item.write_op;
            addr_in     = item.mem_address;
            data_in     = item.write_data;
            enter       = 1'b1;
            enter_stage = i2cee_pkg::STG_START1;
         end
      end else begin
         unique case (stage_ff)
            i2cee_pkg::STG_IDLE: begin
            end
            i2cee_pkg::STG_START1, i2cee_pkg::STG_START2: begin
               unique case (phase_ff)
                  i2cee_pkg::PH_0: begin
                     sda_in   = 1'b1;
                     phase_in = i2cee_pkg::PH_1;
                  end
                  i2cee_pkg::PH_1: begin
                     scl_in   = 1'b1;
                     phase_in = i2cee_pkg::PH_2;
                  end
                  i2cee_pkg::PH_2: begin
                     sda_in   = 1'b0;
                     phase_in = i2cee_pkg::PH_3;
                  end
                  i2cee_pkg::PH_3: begin
                     scl_in      = 1'b0;
                     enter       = 1'b1;
                     enter_stage = i2cee_pkg::stage_type'(stage_ff + 4'd1);
                  end
               endcase
            end
            i2cee_pkg::STG_TXDEVW, i2cee_pkg::STG_TXADDR,
            i2cee_pkg::STG_TXDATA, i2cee_pkg::STG_TXDEVR: begin
               unique case (phase_ff)
                  i2cee_pkg::PH_0: begin
                     scl_in   = 1'b0;
                     phase_in = i2cee_pkg::PH_1;
                  end
                  i2cee_pkg::PH_1: begin
                     sda_in   = shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = i2cee_pkg::PH_2;
                  end
                  i2cee_pkg::PH_2: begin
                     scl_in = 1'b1;
                     if (bit_ff == 3'd7) begin
                        phase_in = i2cee_pkg::PH_3;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = i2cee_pkg::PH_0;
                     end
                  end
                  i2cee_pkg::PH_3: begin
                     scl_in      = 1'b0;
                     enter       = 1'b1;
                     enter_stage = i2cee_pkg::stage_type'(stage_ff + 4'd1);
                  end
               endcase
            end
            i2cee_pkg::STG_ACK1, i2cee_pkg::STG_ACK2,
            i2cee_pkg::STG_ACK3, i2cee_pkg::STG_ACK4: begin
               unique case (phase_ff)
                  i2cee_pkg::PH_0: begin
                     sda_in   = 1'b1;
                     phase_in = i2cee_pkg::PH_1;
                  end
                  i2cee_pkg::PH_1: begin
                     scl_in     = 1'b1;
                     ack_cnt_in = '0;
                     phase_in   = i2cee_pkg::PH_2;
                  end
                  i2cee_pkg::PH_2: begin
                     // Keep waiting while SDA stays high and the limit is not reached.
                     if (item.sda_in && (ack_cnt_ff < cfg.ack_wait_limit)) begin
                        ack_cnt_in = ack_cnt_ff + 1'b1;
                     end else begin
                        phase_in = i2cee_pkg::PH_3;
                     end
                  end
                  i2cee_pkg::PH_3: begin
                     scl_in = 1'b0;
                     enter  = 1'b1;
                     unique case (stage_ff)
                        i2cee_pkg::STG_ACK1: enter_stage = i2cee_pkg::STG_TXADDR;
                        i2cee_pkg::STG_ACK2: enter_stage = op_write_ff ?
                           i2cee_pkg::STG_TXDATA : i2cee_pkg::STG_START2;
                        i2cee_pkg::STG_ACK3: enter_stage = i2cee_pkg::STG_STOP;
                        default:             enter_stage = i2cee_pkg::STG_RX;
                     endcase
                  end
               endcase
            end
            i2cee_pkg::STG_RX: begin
               unique case (phase_ff)
                  i2cee_pkg::PH_0: begin
                     scl_in   = 1'b0;
                     phase_in = i2cee_pkg::PH_1;
                  end
                  i2cee_pkg::PH_1: begin
                     sda_in   = 1'b1;
                     bit_in   = '0;
                     shift_in = '0;
                     phase_in = i2cee_pkg::PH_2;
                  end
                  i2cee_pkg::PH_2: begin
                     scl_in   = 1'b1;
                     phase_in = i2cee_pkg::PH_3;
                  end
                  i2cee_pkg::PH_3: begin
                     shift_in = rx_byte;
                     scl_in   = 1'b0;
                     if (bit_ff == 3'd7) begin
                        rd_result_in = rx_byte;
                        enter        = 1'b1;
                        enter_stage  = i2cee_pkg::STG_STOP;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = i2cee_pkg::PH_2;
                     end
                  end
               endcase
            end
            i2cee_pkg::STG_STOP: begin
               unique case (phase_ff)
                  i2cee_pkg::PH_0: begin
                     sda_in   = 1'b0;
                     phase_in = i2cee_pkg::PH_1;
                  end
                  i2cee_pkg::PH_1: begin
                     scl_in   = 1'b1;
                     phase_in = i2cee_pkg::PH_2;
                  end
                  i2cee_pkg::PH_2: begin
                     sda_in      = 1'b1;
                     settle_in   = '0;
                     enter       = 1'b1;
                     enter_stage = i2cee_pkg::STG_SETTLE;
                  end
                  i2cee_pkg::PH_3: begin
                     stage_in = i2cee_pkg::STG_IDLE;
                     phase_in = i2cee_pkg::PH_0;
                  end
               endcase
            end
            i2cee_pkg::STG_SETTLE: begin
               if (settle_ff >= settle_limit) begin
                  stage_in = i2cee_pkg::STG_IDLE;
                  phase_in = i2cee_pkg::PH_0;
                  done     = 1'b1;
               end else begin
                  settle_in = settle_ff + 1'b1;
               end
            end
            default: begin
               stage_in = i2cee_pkg::STG_IDLE;
               phase_in = i2cee_pkg::PH_0;
            end
         endcase
      end

      // Entering a stage restarts the bit count and, for a transmit stage, loads the byte to send.
      if (enter) begin
         stage_in = enter_stage;
         phase_in = i2cee_pkg::PH_0;
         bit_in   = '0;
         unique case (enter_stage)
            i2cee_pkg::STG_TXDEVW: shift_in = i2cee_pkg::DevSelWrite;
            i2cee_pkg::STG_TXADDR: shift_in = addr_ff;
            i2cee_pkg::STG_TXDATA: shift_in = data_ff;
            i2cee_pkg::STG_TXDEVR: shift_in = i2cee_pkg::DevSelRead;
            default: begin
            end
         endcase
      end
   end

   assign result.scl       = scl_in;
   assign result.sda_out   = sda_in;
   assign result.busy_res  = (stage_in != i2cee_pkg::STG_IDLE);
   assign result.read_data = rd_result_in;
   assign result.done_res  = done;

endmodule

/* hw/rtl/i2c_eeprom_byte_access_master.sv */
// Path: an accepted item goes into the input register, then through the sequencer into
// the result register once the result slot frees. Throughput: one item per cycle while
// rsp_ready does not stall the result; while a result waits, the input register can still take one new item.
// Reset (synchronous, active high) clears both pipeline stages, puts the sequencer in
// idle with SCL and SDA released, and loads the register defaults 255, 5000 and 100.
// Depends on i2cee_pkg and i2cee_core.
module i2c_eeprom_byte_access_master #(
   parameter logic [i2cee_pkg::AckLimitWidth-1:0] AckWaitLimitReset =
      i2cee_pkg::AckWaitLimitReset,
   parameter logic [i2cee_pkg::SettleWidth-1:0] WriteSettleTicksReset =
      i2cee_pkg::WriteSettleTicksReset,
   parameter logic [i2cee_pkg::SettleWidth-1:0] ReadSettleTicksReset =
      i2cee_pkg::ReadSettleTicksReset
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  i2cee_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output i2cee_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [i2cee_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [i2cee_pkg::CsrDataWidth-1:0]   csr_data
);

   i2cee_pkg::cfg_type         cfg_ff;
   logic                       in_valid_ff;
   i2cee_pkg::req_payload_type in_item_ff;
   logic                       out_valid_ff;
   i2cee_pkg::rsp_payload_type out_item_ff;
   i2cee_pkg::rsp_payload_type core_result;
   logic                       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_wait_limit     <= AckWaitLimitReset;
         cfg_ff.write_settle_ticks <= WriteSettleTicksReset;
         cfg_ff.read_settle_ticks  <= ReadSettleTicksReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            i2cee_pkg::CSR_ACK_WAIT_LIMIT:
               cfg_ff.ack_wait_limit <= csr_data[i2cee_pkg::AckLimitWidth-1:0];
            i2cee_pkg::CSR_WRITE_SETTLE_TICKS:
               cfg_ff.write_settle_ticks <= csr_data[i2cee_pkg::SettleWidth-1:0];
            i2cee_pkg::CSR_READ_SETTLE_TICKS:
               cfg_ff.read_settle_ticks <= csr_data[i2cee_pkg::SettleWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // The sequencer steps when the input stage holds an item and the result slot frees.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   i2cee_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule
